### sv/integer_matrix_multiply_macros.svh
// Assertion macros used by the checker file of the matrix multiply block
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define IMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("integer_matrix_multiply: assertion failed");

// next-cycle implication, disabled while reset is low
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("integer_matrix_multiply: assertion failed");

`endif

### sv/imm_pkg.sv
// Package: shared types and constants of the integer matrix multiply block
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam int         RESULT_LIMIT = 16;
    localparam logic [4:0] SIZE_RESET   = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

endpackage

`default_nettype wire

### sv/imm_if.sv
// Channel interfaces: configuration write, command input and result output
`timescale 1ns / 1ps
`default_nettype none

interface imm_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] element_value;

    modport source (output valid, output cmd, output row_index, output col_index,
                    output element_value, input ready);
    modport sink   (input valid, input cmd, input row_index, input col_index,
                    input element_value, output ready);
endinterface

interface imm_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic signed [31:0] product_value;
    logic               last_in_row;

    modport source (output valid, output out_row, output out_col, output product_value,
                    output last_in_row, input ready);
    modport sink   (input valid, input out_row, input out_col, input product_value,
                    input last_in_row, output ready);
endinterface

`default_nettype wire

### sv/imm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/integer_matrix_multiply.sv
// Top level: square integer matrix multiply over two element memories
//
//  channel  dir  handshake     payload
//  i_cfg    in   valid/ready   data: matrix_size (5 bits)
//  i_in     in   valid/ready   cmd, row_index, col_index, element_value
//  o_out    out  valid/ready   out_row, out_col, product_value, last_in_row
//
// A compute of row r at size n runs n columns; each column issues n reads (one A and
// one B word a cycle, set by the single read port of each memory) through a read,
// multiply, accumulate pipeline, then waits for the result register.
// Reset (synchronous, active low) sets matrix_size to 16 and clears control state.
// A stalled result holds the engine; i_in is ready only between row computations.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply #(
    parameter int MAX_DIM = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    imm_cfg_if.sink      i_cfg,
    imm_in_if.sink       i_in,
    imm_out_if.source    o_out
);

    import imm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIMIT = (MAX_DIM < RESULT_LIMIT) ? MAX_DIM : RESULT_LIMIT;

    t_state      r_state, n_state;
    logic [4:0]  r_size;
    logic [3:0]  r_row, n_row;
    logic [3:0]  r_col, n_col;
    logic [3:0]  r_k, n_k;

    logic        r_p1_vld, r_p1_first, r_p1_last;
    logic        r_p2_vld, r_p2_first, r_p2_last;
    logic [31:0] r_p2_prod;
    logic [31:0] r_acc;
    logic        r_acc_done, n_acc_done;

    logic        r_out_vld, n_out_vld;
    logic [3:0]  r_out_row, r_out_col;
    logic [31:0] r_out_val;
    logic        r_out_last;
    logic        w_load;

    logic [4:0]    w_n;
    logic          w_in_xfer;
    logic          w_in_range;
    logic          w_we_a, w_we_b;
    logic [AW-1:0] w_waddr, w_a_raddr, w_b_raddr;
    logic [31:0]   w_a_rdata, w_b_rdata;
    logic [31:0]   w_prod;
    logic          w_issue, w_k_last, w_col_last;

    assign w_n = (r_size == 5'd0)        ? 5'd1 :
                 (r_size > 5'(LIMIT))    ? 5'(LIMIT) : r_size;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in.valid && i_in.ready;

    assign w_in_range = (int'(i_in.row_index) < MAX_DIM) && (int'(i_in.col_index) < MAX_DIM);
    assign w_we_a     = w_in_xfer && (i_in.cmd == CMD_WRITE_A) && w_in_range;
    assign w_we_b     = w_in_xfer && (i_in.cmd == CMD_WRITE_B) && w_in_range;
    assign w_waddr    = AW'(int'(i_in.row_index) * MAX_DIM + int'(i_in.col_index));
    assign w_a_raddr  = AW'(int'(r_row) * MAX_DIM + int'(r_k));
    assign w_b_raddr  = AW'(int'(r_k) * MAX_DIM + int'(r_col));

    imm_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_in.element_value),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    imm_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_in.element_value),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    assign w_issue    = (r_state == S_RUN);
    assign w_k_last   = ({1'b0, r_k} == (w_n - 5'd1));
    assign w_col_last = ({1'b0, r_col} == (w_n - 5'd1));
    assign w_prod     = w_a_rdata * w_b_rdata;
    assign w_load     = (r_state == S_DRAIN) && r_acc_done && (!r_out_vld || o_out.ready);

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        n_acc_done = r_acc_done;
        n_out_vld  = r_out_vld;
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end
        if (r_p2_vld && r_p2_last) begin
            n_acc_done = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (i_in.cmd == CMD_COMPUTE) && ({1'b0, i_in.row_index} < w_n)) begin
                    n_row   = i_in.row_index;
                    n_col   = 4'd0;
                    n_k     = 4'd0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_k = r_k + 4'd1;
                if (w_k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_load) begin
                    n_out_vld  = 1'b1;
                    n_acc_done = 1'b0;
                    n_k        = 4'd0;
                    if (w_col_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_col   = r_col + 4'd1;
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_size     <= SIZE_RESET;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_acc_done <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p1_vld   <= w_issue;
            r_p2_vld   <= r_p1_vld;
            r_acc_done <= n_acc_done;
            r_out_vld  <= n_out_vld;
            if (i_cfg.valid && i_cfg.ready) begin
                r_size <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_k        <= n_k;
        r_p1_first <= (r_k == 4'd0);
        r_p1_last  <= w_k_last;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_prod  <= w_prod;
        if (r_p2_vld) begin
            r_acc <= (r_p2_first ? 32'd0 : r_acc) + r_p2_prod;
        end
        if (w_load) begin
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_val  <= r_acc;
            r_out_last <= w_col_last;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.product_value = r_out_val;
    assign o_out.last_in_row   = r_out_last;

endmodule

`default_nettype wire

### sv/imm_checker.sv
// Port-level checker for the integer matrix multiply block, with its bind
`timescale 1ns / 1ps
`default_nettype none

`include "integer_matrix_multiply_macros.svh"

module imm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic [1:0]  i_in_cmd,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  i_out_row,
    input wire logic [3:0]  i_out_col,
    input wire logic [31:0] i_out_value,
    input wire logic        i_out_last
);

    import imm_pkg::*;

    logic w_in_write;
    logic w_out_hold;

    assign w_in_write = i_in_valid && i_in_ready &&
                        ((i_in_cmd == CMD_WRITE_A) || (i_in_cmd == CMD_WRITE_B));
    assign w_out_hold = i_out_valid && !i_out_ready;

    // stalled result keeps its payload
    `IMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_hold, i_out_valid && $stable(i_out_row) && $stable(i_out_col) && $stable(i_out_value) && $stable(i_out_last))

    // after an element write the command input is ready again in the next cycle
    `IMM_ASSERT_NEXT(a_write_one_cycle, i_clk, i_rst_n, w_in_write, i_in_ready)

    // inside a row no new command is taken
    `IMM_ASSERT_SAME(a_row_busy, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready)

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_row   (o_out.out_row),
    .i_out_col   (o_out.out_col),
    .i_out_value (o_out.product_value),
    .i_out_last  (o_out.last_in_row)
);

`default_nettype wire

### tb/tb.sv
// Testbench: integer matrix multiply checked against a predicted product, random stalls
`timescale 1ns / 1ps

module tb;
    import imm_pkg::*;

    localparam int         DIM            = 16;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         RANDOM_ITEMS   = 12;
    localparam int         MAX_GAP        = 17;
    localparam int         DRAIN_CYCLES   = 24;
    localparam int         WATCHDOG_LIMIT = 3000;

    typedef struct {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        last;
    } t_product;

    logic i_clk = 1'b0;
    logic i_rst_n;

    imm_cfg_if cfg_if ();
    imm_in_if  in_if ();
    imm_out_if out_if ();

    integer_matrix_multiply #(.MAX_DIM(DIM)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted state
    logic [31:0] mat_a [DIM*DIM];
    logic [31:0] mat_b [DIM*DIM];
    bit          a_written [DIM*DIM];
    bit          b_written [DIM*DIM];
    logic [4:0]  size_reg = SIZE_RESET;
    t_product    expected_products [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int stuck_cycles   = 0;
    bit in_burst       = 1'b0;
    bit out_burst      = 1'b0;

    function automatic int active_dim();
        int n;
        n = size_reg;
        if (n < 1) n = 1;
        if (n > DIM) n = DIM;
        if (n > RESULT_LIMIT) n = RESULT_LIMIT;
        return n;
    endfunction

    function automatic void predict_command(logic [1:0] cmd, logic [3:0] row, logic [3:0] col,
                                            logic [31:0] value);
        int          n;
        logic [31:0] acc;
        t_product    p;
        case (cmd)
            CMD_WRITE_A: begin
                mat_a[row*DIM + col]     = value;
                a_written[row*DIM + col] = 1'b1;
            end
            CMD_WRITE_B: begin
                mat_b[row*DIM + col]     = value;
                b_written[row*DIM + col] = 1'b1;
            end
            CMD_COMPUTE: begin
                n = active_dim();
                if (row < n) begin
                    for (int c = 0; c < n; c++) begin
                        acc = '0;
                        for (int k = 0; k < n; k++)
                            acc += mat_a[row*DIM + k] * mat_b[k*DIM + c];
                        p.row   = row;
                        p.col   = 4'(c);
                        p.value = acc;
                        p.last  = (c == n - 1);
                        expected_products.push_back(p);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(logic [1:0] cmd, logic [3:0] row, logic [3:0] col,
                             logic [31:0] value);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.cmd           <= cmd;
        in_if.row_index     <= row;
        in_if.col_index     <= col;
        in_if.element_value <= value;
        do @(posedge i_clk); while (!in_if.ready);
        predict_command(cmd, row, col, value);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(logic [4:0] value);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        size_reg = value;
    endtask

    // loads any element the row product would read that was never written, then computes
    task automatic compute_row(logic [3:0] row);
        int n;
        n = active_dim();
        if (row < n) begin
            for (int k = 0; k < n; k++)
                if (!a_written[row*DIM + k])
                    send_item(CMD_WRITE_A, row, 4'(k), $urandom);
            for (int k = 0; k < n; k++)
                for (int c = 0; c < n; c++)
                    if (!b_written[k*DIM + c])
                        send_item(CMD_WRITE_B, 4'(k), 4'(c), $urandom);
        end
        send_item(CMD_COMPUTE, row, 4'($urandom_range(0, 15)), $urandom);
    endtask

    // reset size first, then oversized settings that clamp to the full store
    task automatic test_max_size();
        compute_row(4'd0);
        write_size(5'd31);
        compute_row(4'd0);
        write_size(5'd17);
        compute_row(4'd0);
        write_size(5'd16);
    endtask

    task automatic test_value_extremes();
        write_size(5'd2);
        send_item(CMD_WRITE_A, 4'd0, 4'd0, 32'h8000_0000);
        send_item(CMD_WRITE_A, 4'd0, 4'd1, 32'h7FFF_FFFF);
        send_item(CMD_WRITE_A, 4'd1, 4'd0, 32'hFFFF_FFFF);
        send_item(CMD_WRITE_A, 4'd1, 4'd1, 32'h0000_0000);
        send_item(CMD_WRITE_B, 4'd0, 4'd0, 32'hFFFF_FFFF);
        send_item(CMD_WRITE_B, 4'd0, 4'd1, 32'h8000_0000);
        send_item(CMD_WRITE_B, 4'd1, 4'd0, 32'h7FFF_FFFF);
        send_item(CMD_WRITE_B, 4'd1, 4'd1, 32'hFFFF_FFFF);
        compute_row(4'd0);
        compute_row(4'd1);
        // rows past the size in use give nothing
        send_item(CMD_COMPUTE, 4'd2, 4'hF, 32'hFFFF_FFFF);
        send_item(CMD_COMPUTE, 4'd15, 4'h0, 32'h0);
    endtask

    task automatic test_size_zero();
        write_size(5'd0);
        send_item(CMD_WRITE_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(CMD_WRITE_B, 4'd0, 4'd0, 32'h7FFF_FFFF);
        compute_row(4'd0);
        send_item(CMD_COMPUTE, 4'd1, 4'd0, 32'h0);
    endtask

    // elements written outside the size in use must survive until the size grows
    task automatic test_kept_outside_size();
        write_size(5'd1);
        send_item(CMD_WRITE_A, 4'd0, 4'd3, 32'h1234_5678);
        send_item(CMD_WRITE_B, 4'd3, 4'd0, 32'h9ABC_DEF1);
        send_item(CMD_WRITE_B, 4'd3, 4'd3, 32'hFFFF_FFFE);
        compute_row(4'd0);
        write_size(5'd4);
        compute_row(4'd0);
    endtask

    task automatic test_unused_command();
        send_item(CMD_UNUSED, 4'hF, 4'hF, 32'hFFFF_FFFF);
        send_item(CMD_UNUSED, 4'h0, 4'h0, 32'h0000_0000);
        compute_row(4'd3);
    endtask

    task automatic test_random_traffic();
        int          start;
        int          n;
        int          pick;
        int          len;
        logic [4:0]  sz;
        logic [1:0]  wcmd;
        logic [31:0] value;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      sz = 5'($urandom_range(1, 4));
            else if (pick < 80) sz = 5'($urandom_range(5, 8));
            else if (pick < 92) sz = 5'($urandom_range(9, 16));
            else if (pick < 96) sz = 5'd0;
            else                sz = 5'($urandom_range(17, 31));
            write_size(sz);
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            n   = active_dim();
            len = $urandom_range(8, 30);
            repeat (len) begin
                pick  = $urandom_range(0, 99);
                wcmd  = $urandom_range(0, 1) ? CMD_WRITE_B : CMD_WRITE_A;
                value = ($urandom_range(0, 7) == 0) ? 32'h8000_0000 : $urandom;
                if (pick < 50)
                    send_item(wcmd, 4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)),
                              value);
                else if (pick < 60)
                    send_item(wcmd, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), value);
                else if (pick < 88)
                    compute_row(4'($urandom_range(0, n - 1)));
                else if (pick < 95)
                    compute_row(4'($urandom_range(0, 15)));
                else
                    send_item(CMD_UNUSED, 4'($urandom), 4'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.data         <= '0;
        in_if.valid         <= 1'b0;
        in_if.cmd           <= CMD_WRITE_A;
        in_if.row_index     <= '0;
        in_if.col_index     <= '0;
        in_if.element_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_max_size();
        test_value_extremes();
        test_size_zero();
        test_kept_outside_size();
        test_unused_command();
        test_random_traffic();

        in_burst  = 1'b0;
        out_burst = 1'b0;
        wait_idle();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: random stall before each transfer, then compare with the oldest prediction
    initial begin : result_sink
        int       stall;
        t_product want;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && out_if.valid && out_if.ready));
            if (expected_products.size() == 0) begin
                report_mismatch("unexpected result", out_if.product_value,
                                {24'b0, out_if.out_row, out_if.out_col});
            end else begin
                want = expected_products.pop_front();
                if (out_if.out_row !== want.row)
                    report_mismatch("out_row", out_if.out_row, want.row);
                if (out_if.out_col !== want.col)
                    report_mismatch("out_col", out_if.out_col, want.col);
                if (out_if.product_value !== want.value)
                    report_mismatch("product_value", out_if.product_value, want.value);
                if (out_if.last_in_row !== want.last)
                    report_mismatch("last_in_row", out_if.last_in_row, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
